FILE: hw/rtl/sdda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdda_pkg
// Shared command codes for the dashed symmetric DDA line rasteriser.
// ----------------------------------------------------------------------------
package sdda_pkg;

    // command carried in the input tuser bit
    localparam logic CMD_LINE = 1'b0;   // latch endpoints, start a new line
    localparam logic CMD_TICK = 1'b1;   // emit the current point, advance one step

endpackage : sdda_pkg
`default_nettype wire

FILE: hw/rtl/sdda_setup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdda_setup
// Line setup: step count S (power of two above the larger delta), its log,
// signed per-step increments in fixed point and the start positions.
// ----------------------------------------------------------------------------
module sdda_setup #(
    parameter int COORD_BITS = 10
) (
    input  wire  logic [COORD_BITS-1:0]   i_x_start,
    input  wire  logic [COORD_BITS-1:0]   i_y_start,
    input  wire  logic [COORD_BITS-1:0]   i_x_end,
    input  wire  logic [COORD_BITS-1:0]   i_y_end,
    output logic [COORD_BITS+1:0]         o_x_inc,
    output logic [COORD_BITS+1:0]         o_y_inc,
    output logic [COORD_BITS:0]           o_total_steps,
    output logic [2*COORD_BITS-1:0]       o_x_pos,
    output logic [2*COORD_BITS-1:0]       o_y_pos
);
    import sdda_pkg::*;

    localparam int LG_W = $clog2(COORD_BITS + 1);

    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic        [COORD_BITS-1:0] ax;
    logic        [COORD_BITS-1:0] ay;
    logic        [COORD_BITS-1:0] m;
    logic        [LG_W-1:0]       lg;
    logic        [LG_W-1:0]       sh;
    logic signed [COORD_BITS+1:0] dx_ext;
    logic signed [COORD_BITS+1:0] dy_ext;

    always_comb begin
        dx = $signed({1'b0, i_x_end}) - $signed({1'b0, i_x_start});
        dy = $signed({1'b0, i_y_end}) - $signed({1'b0, i_y_start});
        ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        m  = (ax > ay) ? ax : ay;

        // bit length of the larger delta; S = 2^lg
        lg = '0;
        for (int k = 0; k < COORD_BITS; k++) begin
            if (m[k]) begin
                lg = LG_W'(k + 1);
            end
        end
        sh = LG_W'(COORD_BITS) - lg;

        dx_ext = {dx[COORD_BITS], dx};
        dy_ext = {dy[COORD_BITS], dy};
    end

    // delta / S in COORD_BITS fraction bits is an exact left shift
    assign o_x_inc       = dx_ext <<< sh;
    assign o_y_inc       = dy_ext <<< sh;
    assign o_total_steps = (COORD_BITS+1)'(1) << lg;
    assign o_x_pos       = {i_x_start, COORD_BITS'(0)};
    assign o_y_pos       = {i_y_start, COORD_BITS'(0)};

endmodule : sdda_setup
`default_nettype wire

FILE: hw/rtl/dashed_symmetric_dda_line.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dashed_symmetric_dda_line
// Symmetric DDA line rasteriser with a mirrored dash pattern on the points.
// ----------------------------------------------------------------------------
// Path: a tick beat's point passes the input register, then the result
//   register, before it leaves on m_axis.
// Throughput: one beat per cycle while m_axis does not stall; each tick is one accumulator add per axis.
// Reset: synchronous, active low; pipeline empty, no line in progress.
// ----------------------------------------------------------------------------
module dashed_symmetric_dda_line #(
    parameter int COORD_BITS = 10
) (
    input  wire  logic                                   i_clk,
    input  wire  logic                                   i_rst_n,
    input  wire  logic                                   s_axis_tvalid,
    output logic                                         s_axis_tready,
    // x_start, y_start, x_end, y_end (lowest first), zero padded
    input  wire  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // command
    input  wire  logic                                   s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  wire  logic                                   m_axis_tready,
    // x_pos, y_pos (lowest first), zero padded
    output logic [((4*COORD_BITS+7)/8)*8-1:0]            m_axis_tdata,
    // plot
    output logic                                         m_axis_tuser,
    output logic                                         m_axis_tlast
);
    import sdda_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int POS_W = 2 * COORD_BITS;
    localparam int INC_W = COORD_BITS + 2;
    localparam int STP_W = COORD_BITS + 1;
    localparam int DAT_W = ((4 * COORD_BITS + 7) / 8) * 8;

    // input register
    logic                 r_in_valid;
    logic                 r_in_cmd;
    logic [CB-1:0]        r_in_xs;
    logic [CB-1:0]        r_in_ys;
    logic [CB-1:0]        r_in_xe;
    logic [CB-1:0]        r_in_ye;

    // line state
    logic                 r_busy;
    logic [POS_W-1:0]     r_x_acc;
    logic [POS_W-1:0]     r_y_acc;
    logic [INC_W-1:0]     r_x_inc;
    logic [INC_W-1:0]     r_y_inc;
    logic [STP_W-1:0]     r_total;
    logic [STP_W-1:0]     r_index;

    // result register
    logic                 r_out_valid;
    logic [POS_W-1:0]     r_out_x;
    logic [POS_W-1:0]     r_out_y;
    logic                 r_out_plot;
    logic                 r_out_last;

    logic [INC_W-1:0]     su_x_inc;
    logic [INC_W-1:0]     su_y_inc;
    logic [STP_W-1:0]     su_total;
    logic [POS_W-1:0]     su_x_pos;
    logic [POS_W-1:0]     su_y_pos;

    logic                 advance;
    logic                 emit;
    logic                 n_plot;
    logic                 n_last;
    logic [STP_W:0]       index_p1;

    sdda_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_x_start     (r_in_xs),
        .i_y_start     (r_in_ys),
        .i_x_end       (r_in_xe),
        .i_y_end       (r_in_ye),
        .o_x_inc       (su_x_inc),
        .o_y_inc       (su_y_inc),
        .o_total_steps (su_total),
        .o_x_pos       (su_x_pos),
        .o_y_pos       (su_y_pos)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign emit          = advance && (r_in_cmd == CMD_TICK) && r_busy;

    always_comb begin
        index_p1 = {1'b0, r_index} + (STP_W+1)'(1);
        n_last   = index_p1 >= {1'b0, r_total};
        // mirrored dash: even steps in the first half, odd steps in the second; a single-step line always plots
        if (r_total == STP_W'(1)) begin
            n_plot = 1'b1;
        end else if (r_index < (r_total >> 1)) begin
            n_plot = !r_index[0];
        end else begin
            n_plot = r_index[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_index     <= '0;
            r_total     <= STP_W'(1);
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
                r_in_cmd   <= s_axis_tuser;
                r_in_xs    <= s_axis_tdata[CB-1:0];
                r_in_ys    <= s_axis_tdata[2*CB-1:CB];
                r_in_xe    <= s_axis_tdata[3*CB-1:2*CB];
                r_in_ye    <= s_axis_tdata[4*CB-1:3*CB];
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (advance && (r_in_cmd == CMD_LINE)) begin
                r_busy  <= 1'b1;
                r_index <= '0;
                r_total <= su_total;
                r_x_inc <= su_x_inc;
                r_y_inc <= su_y_inc;
                r_x_acc <= su_x_pos;
                r_y_acc <= su_y_pos;
            end else if (emit) begin
                r_out_x    <= r_x_acc;
                r_out_y    <= r_y_acc;
                r_out_plot <= n_plot;
                r_out_last <= n_last;
                r_x_acc    <= r_x_acc + {{(POS_W-INC_W){r_x_inc[INC_W-1]}}, r_x_inc};
                r_y_acc    <= r_y_acc + {{(POS_W-INC_W){r_y_inc[INC_W-1]}}, r_y_inc};
                if (n_last) begin
                    r_busy  <= 1'b0;
                    r_index <= '0;
                end else begin
                    r_index <= index_p1[STP_W-1:0];
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DAT_W'({r_out_y, r_out_x});
    assign m_axis_tuser  = r_out_plot;
    assign m_axis_tlast  = r_out_last;

endmodule : dashed_symmetric_dda_line
`default_nettype wire
